[src/qubit_measurement_engine_unit_defines.svh]
// assertion macros shared by the engine modules
// expects clk and arst_n in the scope of each use
`ifndef QUBIT_MEASUREMENT_ENGINE_UNIT_DEFINES_SVH
`define QUBIT_MEASUREMENT_ENGINE_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define QME_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("qme assertion failed");

// next-cycle implication, checked outside reset
`define QME_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("qme assertion failed");

`endif

[src/qme_pkg.sv]
// shared constants, codes and types of the qubit measurement engine
// no dependencies
package qme_pkg;

	localparam int MAX_QUBITS = 10;
	localparam int AMP_WIDTH  = 16;
	localparam int FRAC_BITS  = AMP_WIDTH - 1;
	localparam int ADDR_W     = MAX_QUBITS;
	localparam int DEPTH      = 1 << ADDR_W;
	localparam int WORD_W     = 2 * AMP_WIDTH;
	localparam int RES_W      = 43;
	localparam int P_W        = RES_W - 1;
	localparam int QC_W       = 4;
	localparam int QB_W       = 4;
	localparam int CMD_W      = 3;
	localparam int IDX_W      = 10;
	localparam int ST_W       = 2;
	localparam int PROD_W     = 2 * AMP_WIDTH;
	localparam int DIV_W      = PROD_W + 2 * FRAC_BITS;
	localparam int RAD_W      = 2 * AMP_WIDTH;
	localparam int STEP_W     = $clog2(DIV_W);
	localparam int FIFO_DEPTH = 2;
	localparam int FPTR_W     = $clog2(FIFO_DEPTH);

	localparam logic [QC_W-1:0] QC_RESET = QC_W'(MAX_QUBITS);

	// command codes
	localparam logic [CMD_W-1:0] CMD_LOAD  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PROB  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_EXPT  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_COLL  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;

	// pauli basis codes
	localparam logic [1:0] BASIS_X = 2'd0;
	localparam logic [1:0] BASIS_Y = 2'd1;
	localparam logic [1:0] BASIS_Z = 2'd2;

	// status codes
	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_QUBIT = 2'd1;
	localparam logic [ST_W-1:0] ST_BAD   = 2'd2;
	localparam logic [ST_W-1:0] ST_ZERO  = 2'd3;

	localparam logic signed [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
	localparam logic signed [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};
	localparam logic [RAD_W-1:0] AMP_MAX_U = RAD_W'((1 << (AMP_WIDTH - 1)) - 1);

	typedef enum logic [2:0] {
		OP_LOAD, OP_PROB, OP_EXPX, OP_EXPY, OP_EXPZ, OP_COLL, OP_READ, OP_ERR
	} op_t;

	// classified command handed from front to back
	typedef struct packed {
		op_t                          op;
		logic [ST_W-1:0]              status;
		logic [ADDR_W-1:0]            first;
		logic [ADDR_W-1:0]            last;
		logic [ADDR_W-1:0]            mask;
		logic signed [AMP_WIDTH-1:0]  re;
		logic signed [AMP_WIDTH-1:0]  im;
		logic                         outcome;
	} desc_t;

	typedef enum logic [3:0] {
		B_IDLE, B_LOAD, B_SWEEP, B_DRAIN, B_C_CHECK, B_C_RD, B_C_WAIT,
		B_C_RE, B_C_REW, B_C_IM, B_C_IMW, B_C_WR, B_RESULT
	} bstate_t;

	typedef enum logic [2:0] {
		S_IDLE, S_SQ, S_DIV, S_SQRT, S_DONE
	} sstate_t;

endpackage

[src/qme_in_if.sv]
// command channel: valid/ready plus one command beat
// depends on qme_pkg
interface qme_in_if import qme_pkg::*; ();
	logic                        valid;
	logic                        ready;
	logic [CMD_W-1:0]            command;
	logic [IDX_W-1:0]            index;
	logic signed [AMP_WIDTH-1:0] amp_real;
	logic signed [AMP_WIDTH-1:0] amp_imag;
	logic [QB_W-1:0]             qubit;
	logic [1:0]                  basis;
	logic                        outcome;

	modport source(output valid, command, index, amp_real, amp_imag, qubit, basis, outcome,
		input ready);
	modport sink(input valid, command, index, amp_real, amp_imag, qubit, basis, outcome,
		output ready);
endinterface

[src/qme_out_if.sv]
// result channel: valid/ready plus one result beat
// depends on qme_pkg
interface qme_out_if import qme_pkg::*; ();
	logic                        valid;
	logic                        ready;
	logic signed [RES_W-1:0]     result_value;
	logic signed [AMP_WIDTH-1:0] out_real;
	logic signed [AMP_WIDTH-1:0] out_imag;
	logic [ST_W-1:0]             status;

	modport source(output valid, result_value, out_real, out_imag, status, input ready);
	modport sink(input valid, result_value, out_real, out_imag, status, output ready);
endinterface

[src/qme_front.sv]
// front end: accepts command beats, checks them and builds a descriptor
// depends on qme_pkg and qme_in_if
module qme_front import qme_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [QC_W-1:0] qubit_count,
	qme_in_if.sink          req,
	output logic            push_valid,
	output desc_t           push_desc,
	input  logic            push_ready
);

	logic [QC_W-1:0]   n;
	logic [ADDR_W:0]   dim;
	logic [ADDR_W-1:0] last;
	logic [ADDR_W-1:0] idx;
	logic [QB_W-1:0]   sh;
	logic [ADDR_W-1:0] mask;
	logic              qok;
	desc_t             d;
	desc_t             d_s1;
	logic              v_s1;

	// qubits in use, state size and target bit
	always_comb begin
		if (qubit_count == '0)
			n = QC_W'(1);
		else if (qubit_count > QC_RESET)
			n = QC_RESET;
		else
			n = qubit_count;
		dim  = (ADDR_W + 1)'(1) << n;
		last = ADDR_W'(dim - (ADDR_W + 1)'(1));
		idx  = req.index[ADDR_W-1:0] & last;
		qok  = req.qubit < n;
		sh   = n - req.qubit - QB_W'(1);
		mask = ADDR_W'(1) << sh;
	end

	// classify the command
	always_comb begin
		d         = '0;
		d.first   = '0;
		d.last    = last;
		d.mask    = mask;
		d.re      = req.amp_real;
		d.im      = req.amp_imag;
		d.outcome = req.outcome;
		d.status  = ST_OK;
		unique case (req.command)
			CMD_LOAD: begin
				d.op    = OP_LOAD;
				d.first = idx;
			end
			CMD_READ: begin
				d.op    = OP_READ;
				d.first = idx;
				d.last  = idx;
			end
			CMD_PROB, CMD_COLL: begin
				d.op = (req.command == CMD_PROB) ? OP_PROB : OP_COLL;
				if (!qok) begin
					d.op     = OP_ERR;
					d.status = ST_QUBIT;
				end
			end
			CMD_EXPT: begin
				if (!qok) begin
					d.op     = OP_ERR;
					d.status = ST_QUBIT;
				end else begin
					case (req.basis)
						BASIS_X: d.op = OP_EXPX;
						BASIS_Y: d.op = OP_EXPY;
						BASIS_Z: d.op = OP_EXPZ;
						default: begin
							d.op     = OP_ERR;
							d.status = ST_BAD;
						end
					endcase
				end
			end
			default: begin
				d.op     = OP_ERR;
				d.status = ST_BAD;
			end
		endcase
	end

	assign req.ready  = !v_s1 || push_ready;
	assign push_valid = v_s1;
	assign push_desc  = d_s1;

	// descriptor stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (req.ready) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			d_s1 <= d;
		end
	end

endmodule

[src/qme_fifo.sv]
// short descriptor queue between front and back
// depends on qme_pkg
module qme_fifo import qme_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	input  desc_t push_desc,
	output logic  push_ready,
	output logic  pop_valid,
	output desc_t pop_desc,
	input  logic  pop
);

	desc_t              mem_q [FIFO_DEPTH];
	logic [FPTR_W-1:0]  wptr_q;
	logic [FPTR_W-1:0]  rptr_q;
	logic [FPTR_W:0]    count_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = count_q != (FPTR_W + 1)'(FIFO_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_desc   = mem_q[rptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push)
				wptr_q <= wptr_q + FPTR_W'(1);
			if (do_pop)
				rptr_q <= rptr_q + FPTR_W'(1);
			if (do_push && !do_pop)
				count_q <= count_q + (FPTR_W + 1)'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - (FPTR_W + 1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= push_desc;
		end
	end

endmodule

[src/qme_scale.sv]
// collapse renormalizer: sign(a) * floor(sqrt(a*a*2^30 / p)), clamped
// restoring divider then digit-by-digit square root; depends on qme_pkg
module qme_scale import qme_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [AMP_WIDTH:0]          mag,
	input  logic                        neg,
	input  logic [P_W-1:0]              p,
	output logic                        busy,
	output logic                        done,
	output logic signed [AMP_WIDTH-1:0] res
);

	sstate_t            state_q, state_d;
	logic [AMP_WIDTH:0] mag_q;
	logic               neg_q;
	logic [P_W-1:0]     p_q;
	logic [DIV_W-1:0]   div_q;
	logic [P_W-1:0]     rem_q;
	logic [DIV_W-1:0]   quot_q;
	logic [STEP_W-1:0]  step_q;
	logic [RAD_W-1:0]   x_q, r_q, bit_q;
	logic               sat_q;
	logic [P_W:0]       trial;
	logic               take;
	logic [DIV_W-1:0]   quot_n;
	logic [RAD_W-1:0]   rb;
	logic [PROD_W-1:0]  sq;
	logic               last_step;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (start) state_d = S_SQ;
			S_SQ:   state_d = S_DIV;
			S_DIV:  if (last_step) state_d = S_SQRT;
			S_SQRT: if (bit_q == RAD_W'(1)) state_d = S_DONE;
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		busy = state_q != S_IDLE;
		done = state_q == S_DONE;
		res  = '0;
		if (neg_q) begin
			if (sat_q || r_q > AMP_MAX_U + RAD_W'(1))
				res = {1'b1, {(AMP_WIDTH-1){1'b0}}};
			else
				res = AMP_WIDTH'(RAD_W'(0) - r_q);
		end else begin
			if (sat_q || r_q > AMP_MAX_U)
				res = AMP_WIDTH'(AMP_MAX_U);
			else
				res = AMP_WIDTH'(r_q);
		end
	end

	// one quotient bit and one root digit per cycle
	always_comb begin
		sq        = PROD_W'(mag_q) * PROD_W'(mag_q);
		trial     = {rem_q, div_q[DIV_W-1]};
		take      = trial >= {1'b0, p_q};
		quot_n    = {quot_q[DIV_W-2:0], take};
		last_step = step_q == STEP_W'(DIV_W - 1);
		rb        = r_q + bit_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					mag_q <= mag;
					neg_q <= neg;
					p_q   <= p;
				end
			end
			S_SQ: begin
				div_q  <= DIV_W'(sq) << (2 * FRAC_BITS);
				rem_q  <= '0;
				quot_q <= '0;
				step_q <= '0;
			end
			S_DIV: begin
				div_q  <= div_q << 1;
				rem_q  <= take ? P_W'(trial - {1'b0, p_q}) : P_W'(trial);
				quot_q <= quot_n;
				step_q <= step_q + STEP_W'(1);
				if (last_step) begin
					sat_q <= |quot_n[DIV_W-1:RAD_W];
					x_q   <= quot_n[RAD_W-1:0];
					r_q   <= '0;
					bit_q <= RAD_W'(1) << (RAD_W - 2);
				end
			end
			S_SQRT: begin
				if (x_q >= rb) begin
					x_q <= x_q - rb;
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			default: ;
		endcase
	end

endmodule

[src/qme_back.sv]
// back end: amplitude memory, sweep pipeline, collapse sequencer, result register
// depends on qme_pkg, qme_out_if, qme_scale and the assertion macros
`include "qubit_measurement_engine_unit_defines.svh"
module qme_back import qme_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  pop_valid,
	input  desc_t pop_desc,
	output logic  pop,
	qme_out_if.source rsp
);

	bstate_t state_q, state_d;
	desc_t   cur_q;
	logic [ADDR_W-1:0] cnt_q;
	logic [ST_W-1:0]   status_q;

	logic [WORD_W-1:0] mem [DEPTH];
	logic [ADDR_W-1:0] addr_a, addr_b, waddr;
	logic [WORD_W-1:0] wdata, rd_a_s1, rd_b_s1;
	logic              we;

	logic v_s1, incl_s1, neg_s1, incl_d, neg_d, cbit;
	logic v_s2, incl_s2, neg_s2;
	logic signed [PROD_W-1:0] p1_s2, p2_s2, p1, p2;
	logic signed [AMP_WIDTH-1:0] re_a, im_a, re_b, im_b;
	logic signed [RES_W-1:0] acc_q, term;
	logic signed [RES_W:0]   sum;
	logic signed [AMP_WIDTH-1:0] rdre_q, rdim_q, cre_q, cim_q, nre_q, nim_q;

	logic ov_q;
	logic signed [RES_W-1:0]     ores_q;
	logic signed [AMP_WIDTH-1:0] ore_q, oim_q;
	logic [ST_W-1:0]             ost_q;
	logic                        out_load, match, last_hit;

	logic                        sc_start, sc_neg, sc_busy, sc_done;
	logic [AMP_WIDTH:0]          sc_mag;
	logic signed [AMP_WIDTH-1:0] sc_res, sc_src;

	qme_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sc_start),
		.mag    (sc_mag),
		.neg    (sc_neg),
		.p      (acc_q[P_W-1:0]),
		.busy   (sc_busy),
		.done   (sc_done),
		.res    (sc_res)
	);

	assign cbit     = (cnt_q & cur_q.mask) != '0;
	assign match    = cbit == cur_q.outcome;
	assign last_hit = cnt_q == cur_q.last;
	assign out_load = (state_q == B_RESULT) && (!ov_q || rsp.ready);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (pop_valid) begin
					case (pop_desc.op)
						OP_LOAD: state_d = B_LOAD;
						OP_ERR:  state_d = B_RESULT;
						default: state_d = B_SWEEP;
					endcase
				end
			end
			B_LOAD:  state_d = B_RESULT;
			B_SWEEP: if (last_hit) state_d = B_DRAIN;
			B_DRAIN: begin
				if (!v_s1 && !v_s2)
					state_d = (cur_q.op == OP_COLL) ? B_C_CHECK : B_RESULT;
			end
			B_C_CHECK: state_d = (acc_q <= '0) ? B_RESULT : B_C_RD;
			B_C_RD:    state_d = B_C_WAIT;
			B_C_WAIT:  state_d = match ? B_C_RE : B_C_WR;
			B_C_RE:    state_d = B_C_REW;
			B_C_REW:   if (sc_done) state_d = B_C_IM;
			B_C_IM:    state_d = B_C_IMW;
			B_C_IMW:   if (sc_done) state_d = B_C_WR;
			B_C_WR:    state_d = last_hit ? B_RESULT : B_C_RD;
			B_RESULT:  if (out_load) state_d = B_IDLE;
			default:   state_d = B_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		pop      = (state_q == B_IDLE) && pop_valid;
		addr_a   = cnt_q;
		addr_b   = cnt_q | cur_q.mask;
		we       = (state_q == B_LOAD) || (state_q == B_C_WR);
		waddr    = (state_q == B_LOAD) ? cur_q.first : cnt_q;
		wdata    = (state_q == B_LOAD) ? {cur_q.re, cur_q.im} : {nre_q, nim_q};
		sc_start = (state_q == B_C_RE) || (state_q == B_C_IM);
		sc_src   = (state_q == B_C_IM) ? cim_q : cre_q;
		sc_neg   = sc_src[AMP_WIDTH-1];
		sc_mag   = sc_neg ? (AMP_WIDTH + 1)'(-(AMP_WIDTH + 1)'(sc_src))
			: (AMP_WIDTH + 1)'(sc_src);
	end

	// which terms a sweep keeps
	always_comb begin
		incl_d = 1'b0;
		neg_d  = 1'b0;
		case (cur_q.op)
			OP_PROB, OP_EXPX, OP_EXPY: incl_d = !cbit;
			OP_EXPZ: begin
				incl_d = 1'b1;
				neg_d  = cbit;
			end
			OP_COLL: incl_d = match;
			OP_READ: incl_d = 1'b1;
			default: incl_d = 1'b0;
		endcase
	end

	// products and term combine
	always_comb begin
		re_a = rd_a_s1[WORD_W-1:AMP_WIDTH];
		im_a = rd_a_s1[AMP_WIDTH-1:0];
		re_b = rd_b_s1[WORD_W-1:AMP_WIDTH];
		im_b = rd_b_s1[AMP_WIDTH-1:0];
		case (cur_q.op)
			OP_EXPX: begin
				p1 = PROD_W'(re_a) * PROD_W'(re_b);
				p2 = PROD_W'(im_a) * PROD_W'(im_b);
			end
			OP_EXPY: begin
				p1 = PROD_W'(re_a) * PROD_W'(im_b);
				p2 = PROD_W'(im_a) * PROD_W'(re_b);
			end
			default: begin
				p1 = PROD_W'(re_a) * PROD_W'(re_a);
				p2 = PROD_W'(im_a) * PROD_W'(im_a);
			end
		endcase
		case (cur_q.op)
			OP_EXPX: term = (RES_W'(p1_s2) + RES_W'(p2_s2)) <<< 1;
			OP_EXPY: term = (RES_W'(p1_s2) - RES_W'(p2_s2)) <<< 1;
			default: term = RES_W'(p1_s2) + RES_W'(p2_s2);
		endcase
		if (neg_s2)
			term = -term;
		sum = (RES_W + 1)'(acc_q) + (RES_W + 1)'(term);
	end

	// amplitude memory, registered read at two addresses
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rd_a_s1 <= mem[addr_a];
		rd_b_s1 <= mem[addr_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= state_q == B_SWEEP;
			v_s2    <= v_s1;
			if (out_load)
				ov_q <= 1'b1;
			else if (rsp.ready)
				ov_q <= 1'b0;
		end
	end

	// sweep pipeline and sequencer datapath
	always_ff @(posedge clk) begin
		incl_s1 <= incl_d;
		neg_s1  <= neg_d;
		incl_s2 <= incl_s1;
		neg_s2  <= neg_s1;
		p1_s2   <= p1;
		p2_s2   <= p2;
		if (v_s1) begin
			rdre_q <= re_a;
			rdim_q <= im_a;
		end
		if (v_s2 && incl_s2) begin
			if (sum[RES_W] != sum[RES_W-1])
				acc_q <= sum[RES_W] ? RES_MIN : RES_MAX;
			else
				acc_q <= sum[RES_W-1:0];
		end
		case (state_q)
			B_IDLE: begin
				if (pop_valid) begin
					cur_q    <= pop_desc;
					cnt_q    <= pop_desc.first;
					status_q <= pop_desc.status;
					acc_q    <= '0;
				end
			end
			B_SWEEP: cnt_q <= cnt_q + ADDR_W'(1);
			B_C_CHECK: begin
				cnt_q <= cur_q.first;
				if (acc_q <= '0)
					status_q <= ST_ZERO;
			end
			B_C_WAIT: begin
				cre_q <= re_a;
				cim_q <= im_a;
				if (!match) begin
					nre_q <= '0;
					nim_q <= '0;
				end
			end
			B_C_REW: if (sc_done) nre_q <= sc_res;
			B_C_IMW: if (sc_done) nim_q <= sc_res;
			B_C_WR:  cnt_q <= cnt_q + ADDR_W'(1);
			default: ;
		endcase
		if (out_load) begin
			ost_q  <= status_q;
			ores_q <= '0;
			ore_q  <= '0;
			oim_q  <= '0;
			if (status_q == ST_OK) begin
				case (cur_q.op)
					OP_PROB, OP_EXPX, OP_EXPY, OP_EXPZ: ores_q <= acc_q;
					OP_READ: begin
						ores_q <= acc_q;
						ore_q  <= rdre_q;
						oim_q  <= rdim_q;
					end
					default: ores_q <= '0;
				endcase
			end
		end
	end

	assign rsp.valid        = ov_q;
	assign rsp.result_value = ores_q;
	assign rsp.out_real     = ore_q;
	assign rsp.out_imag     = oim_q;
	assign rsp.status       = ost_q;

	`QME_ASSERT_IMP(a_start_idle, sc_start, !sc_busy)
	`QME_ASSERT_IMP(a_write_phase, we, state_q == B_LOAD || state_q == B_C_WR)
	`QME_ASSERT_IMP(a_coll_prob, state_q == B_C_WR, acc_q > '0 && cur_q.op == OP_COLL)
	`QME_ASSERT_NEXT(a_pipe_drain, state_q == B_DRAIN && !v_s1 && !v_s2, !v_s2)

endmodule

[src/qubit_measurement_engine_unit.sv]
// qubit measurement engine: takes command beats and returns one result beat per command
// prob zero and expectation make one memory sweep at one index a cycle
// collapse sweeps as well, then divides and roots each kept amplitude and zeroes each dropped one
// the back end runs one command at a time
// reset clears control and sets qubit_count to 10, memory is not cleared
module qubit_measurement_engine_unit import qme_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [QC_W-1:0] cfg_wdata,
	qme_in_if.sink          req,
	qme_out_if.source       rsp
);

	logic [QC_W-1:0] qubit_count_q;
	logic            f_valid, f_ready, b_valid, b_pop;
	desc_t           f_desc, b_desc;

	// qubit count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			qubit_count_q <= QC_RESET;
		else if (cfg_we)
			qubit_count_q <= cfg_wdata;
	end

	qme_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.qubit_count (qubit_count_q),
		.req         (req),
		.push_valid  (f_valid),
		.push_desc   (f_desc),
		.push_ready  (f_ready)
	);

	qme_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_desc  (f_desc),
		.push_ready (f_ready),
		.pop_valid  (b_valid),
		.pop_desc   (b_desc),
		.pop        (b_pop)
	);

	qme_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (b_valid),
		.pop_desc  (b_desc),
		.pop       (b_pop),
		.rsp       (rsp)
	);

endmodule

[tb/qme_checker.sv]
// response checker for the qubit measurement engine: tracks the state vector,
// predicts every result beat and compares it with the response channel
// depends on qme_pkg, qme_in_if and qme_out_if
module qme_checker import qme_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [QC_W-1:0] cfg_wdata,
	qme_in_if               req,
	qme_out_if              rsp,
	output int              fail_count,
	output int              outstanding
);

	typedef struct {
		logic signed [RES_W-1:0]     value;
		logic signed [AMP_WIDTH-1:0] re;
		logic signed [AMP_WIDTH-1:0] im;
		logic [ST_W-1:0]             status;
	} result_beat_t;

	result_beat_t    awaited_results[$];
	longint          vec_re[DEPTH];
	longint          vec_im[DEPTH];
	logic [QC_W-1:0] qubits_cfg;

	// clamp an accumulated sum to the result range
	function automatic longint clamp_sum(longint s);
		if (s > longint'(RES_MAX)) return longint'(RES_MAX);
		if (s < longint'(RES_MIN)) return longint'(RES_MIN);
		return s;
	endfunction

	function automatic longint unsigned int_root(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// renormalize one part after collapse: truncate a / sqrt(p), clamp to Q1.15
	function automatic longint renorm_part(longint a, longint p);
		longint unsigned mag, q;
		mag = (a < 0) ? -a : a;
		q = int_root(((mag * mag) << (2 * FRAC_BITS)) / p);
		if (a < 0) return (q > 64'd32768) ? -64'sd32768 : -longint'(q);
		return (q > longint'(AMP_MAX_U)) ? longint'(AMP_MAX_U) : longint'(q);
	endfunction

	function automatic longint norm_at(int i);
		return vec_re[i] * vec_re[i] + vec_im[i] * vec_im[i];
	endfunction

	// apply one command to the tracked state and queue its result
	task automatic run_command(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] index,
		input logic signed [AMP_WIDTH-1:0] re, input logic signed [AMP_WIDTH-1:0] im,
		input logic [QB_W-1:0] qb, input logic [1:0] basis, input logic outcome);
		result_beat_t e;
		int n, dim, idx, mask, j;
		longint acc, t, p;
		e = '{value: '0, re: '0, im: '0, status: ST_OK};
		acc = 0;
		mask = 0;
		n = (qubits_cfg < 1) ? 1 : ((qubits_cfg > MAX_QUBITS) ? MAX_QUBITS : qubits_cfg);
		dim = 1 << n;
		idx = index & (dim - 1);
		if (cmd >= CMD_PROB && cmd <= CMD_COLL) begin
			if (qb >= n) e.status = ST_QUBIT;
			else mask = 1 << (n - qb - 1);
		end
		if (cmd == CMD_LOAD) begin
			vec_re[idx] = longint'(re);
			vec_im[idx] = longint'(im);
		end else if (cmd == CMD_PROB && e.status == ST_OK) begin
			for (int i = 0; i < dim; i++)
				if ((i & mask) == 0) acc = clamp_sum(acc + norm_at(i));
		end else if (cmd == CMD_EXPT && e.status == ST_OK) begin
			if (basis != BASIS_X && basis != BASIS_Y && basis != BASIS_Z) begin
				e.status = ST_BAD;
			end else begin
				for (int i = 0; i < dim; i++) begin
					j = i | mask;
					if (basis == BASIS_Z) begin
						acc = clamp_sum(acc + (((i & mask) != 0) ? -norm_at(i) : norm_at(i)));
					end else if ((i & mask) == 0) begin
						if (basis == BASIS_X) t = vec_re[i] * vec_re[j] + vec_im[i] * vec_im[j];
						else t = vec_re[i] * vec_im[j] - vec_im[i] * vec_re[j];
						acc = clamp_sum(acc + 2 * t);
					end
				end
			end
		end else if (cmd == CMD_COLL && e.status == ST_OK) begin
			p = 0;
			for (int i = 0; i < dim; i++)
				if (((i & mask) != 0) == outcome) p = clamp_sum(p + norm_at(i));
			if (p <= 0) begin
				e.status = ST_ZERO;
			end else begin
				for (int i = 0; i < dim; i++) begin
					if (((i & mask) != 0) == outcome) begin
						vec_re[i] = renorm_part(vec_re[i], p);
						vec_im[i] = renorm_part(vec_im[i], p);
					end else begin
						vec_re[i] = 0;
						vec_im[i] = 0;
					end
				end
			end
		end else if (cmd == CMD_READ) begin
			e.re = AMP_WIDTH'(vec_re[idx]);
			e.im = AMP_WIDTH'(vec_im[idx]);
			acc = norm_at(idx);
		end else if (cmd > CMD_READ) begin
			e.status = ST_BAD;
		end
		if (e.status != ST_OK) acc = 0;
		e.value = acc[RES_W-1:0];
		awaited_results.push_back(e);
	endtask

	// compare before predicting so a fresh command never meets an older beat
	always @(posedge clk or negedge arst_n) begin
		result_beat_t e;
		if (!arst_n) begin
			qubits_cfg = QC_RESET;
			awaited_results.delete();
			fail_count = 0;
			outstanding = 0;
			for (int i = 0; i < DEPTH; i++) begin
				vec_re[i] = 0;
				vec_im[i] = 0;
			end
		end else begin
			if (cfg_we) qubits_cfg = cfg_wdata;
			if (rsp.valid && rsp.ready) begin
				if (awaited_results.size() == 0) begin
					$error("result beat with no command waiting");
					fail_count++;
				end else begin
					e = awaited_results.pop_front();
					if (rsp.status !== e.status) begin
						$error("status exp %0d got %0d", e.status, rsp.status);
						fail_count++;
					end
					if (rsp.result_value !== e.value) begin
						$error("result_value exp %0d got %0d", e.value, rsp.result_value);
						fail_count++;
					end
					if (rsp.out_real !== e.re) begin
						$error("out_real exp %0d got %0d", e.re, rsp.out_real);
						fail_count++;
					end
					if (rsp.out_imag !== e.im) begin
						$error("out_imag exp %0d got %0d", e.im, rsp.out_imag);
						fail_count++;
					end
				end
			end
			if (req.valid && req.ready)
				run_command(req.command, req.index, req.amp_real, req.amp_imag,
					req.qubit, req.basis, req.outcome);
			outstanding = awaited_results.size();
		end
	end

endmodule

[tb/tb.sv]
// top of the qubit measurement engine bench: clock, reset, command stimulus
// with bursty issue and a stalling result sink; checking lives in qme_checker
// depends on qme_pkg, qme_in_if, qme_out_if, qme_checker and the engine
module tb;
	import qme_pkg::*;

	localparam logic [1:0]       BASIS_NONE = 2'd3;
	localparam logic [CMD_W-1:0] CMD_UNDEF  = 3'd7;

	logic            clk;
	logic            arst_n;
	logic            cfg_we;
	logic [QC_W-1:0] cfg_wdata;
	int              fail_count;
	int              outstanding;
	int              burst_left;
	bit              hold_request;

	qme_in_if  req();
	qme_out_if rsp();

	qubit_measurement_engine_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (req),
		.rsp      (rsp)
	);

	qme_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.req        (req),
		.rsp        (rsp),
		.fail_count (fail_count),
		.outstanding(outstanding)
	);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// hard stop in case the engine hangs
	initial begin
		#40000000;
		$display("qubit_measurement_engine_unit test failed");
		$finish;
	end

	// result sink: rotating stall patterns, plus one long hold-off on request
	initial begin
		int cyc;
		cyc = 0;
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			cyc++;
			if (hold_request) begin
				hold_request = 1'b0;
				rsp.ready <= 1'b0;
				repeat (300) @(negedge clk);
			end else begin
				case ((cyc / 150) % 3)
					0: rsp.ready <= 1'b1;
					1: rsp.ready <= ($urandom_range(1) == 1);
					default: rsp.ready <= ($urandom_range(3) == 0);
				endcase
			end
		end
	end

	// offer one command beat and wait for it to be taken
	task automatic send(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] index,
		input logic [AMP_WIDTH-1:0] re, input logic [AMP_WIDTH-1:0] im,
		input logic [QB_W-1:0] qb, input logic [1:0] basis, input logic outcome);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		req.valid    <= 1'b1;
		req.command  <= cmd;
		req.index    <= index;
		req.amp_real <= re;
		req.amp_imag <= im;
		req.qubit    <= qb;
		req.basis    <= basis;
		req.outcome  <= outcome;
		do @(posedge clk); while (!req.ready);
		burst_left--;
	endtask

	// drop valid and wait until every result beat has come back
	task automatic settle();
		@(negedge clk);
		req.valid <= 1'b0;
		burst_left = 0;
		while (outstanding != 0) @(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	task automatic set_qubits(input logic [QC_W-1:0] v);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [AMP_WIDTH-1:0] pick_amp();
		case ($urandom_range(9))
			0, 1: return '0;
			2: return 16'h7fff;
			3: return 16'h8000;
			default: return AMP_WIDTH'($urandom());
		endcase
	endfunction

	task automatic load_all(input int n);
		for (int i = 0; i < (1 << n); i++)
			send(CMD_LOAD, IDX_W'(i), pick_amp(), pick_amp(), '0, BASIS_X, 1'b0);
	endtask

	// one random command; every index below 2^n is already written
	task automatic random_command(input int n, input bit cheap_only);
		int k;
		logic [QB_W-1:0] qb;
		logic [CMD_W-1:0] cmd;
		k = cheap_only ? (($urandom_range(1) == 0) ? 0 : 80) : $urandom_range(99);
		qb = ($urandom_range(9) == 0) ? QB_W'($urandom_range(15)) : QB_W'($urandom_range(n - 1));
		if (k < 30) cmd = CMD_LOAD;
		else if (k < 45) cmd = CMD_PROB;
		else if (k < 62) cmd = CMD_EXPT;
		else if (k < 72) cmd = CMD_COLL;
		else if (k < 94) cmd = CMD_READ;
		else cmd = CMD_READ + CMD_W'($urandom_range(1, 3));
		send(cmd, IDX_W'($urandom_range(1023)), pick_amp(), pick_amp(), qb,
			2'($urandom_range(3)), 1'($urandom_range(1)));
	endtask

	task automatic random_phase(input logic [QC_W-1:0] qc, input int n, input int count);
		set_qubits(qc);
		load_all(n);
		repeat (count) random_command(n, 1'b0);
	endtask

	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		burst_left   = 0;
		hold_request = 1'b0;
		req.valid    = 1'b0;
		req.command  = CMD_LOAD;
		req.index    = '0;
		req.amp_real = '0;
		req.amp_imag = '0;
		req.qubit    = '0;
		req.basis    = BASIS_X;
		req.outcome  = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset size: only entries written here are read back
		send(CMD_LOAD, 10'd0, 16'h7fff, 16'h8000, '0, BASIS_X, 1'b0);
		send(CMD_LOAD, 10'd1023, 16'h8000, 16'h7fff, '0, BASIS_X, 1'b0);
		send(CMD_READ, 10'd0, '0, '0, '0, BASIS_X, 1'b0);
		send(CMD_READ, 10'd1023, '0, '0, '0, BASIS_X, 1'b0);
		send(CMD_PROB, 10'd0, '0, '0, 4'd15, BASIS_X, 1'b0);
		send(CMD_EXPT, 10'd0, '0, '0, 4'd10, BASIS_NONE, 1'b0);
		send(CMD_UNDEF, 10'd0, '0, '0, '0, BASIS_X, 1'b0);

		// single qubit: every measurement and the zero probability collapse
		set_qubits(4'd1);
		send(CMD_LOAD, 10'd0, 16'h7fff, 16'h8000, '0, BASIS_X, 1'b0);
		send(CMD_LOAD, 10'd1, 16'h8000, 16'h7fff, '0, BASIS_X, 1'b0);
		send(CMD_PROB, 10'd0, '0, '0, 4'd0, BASIS_X, 1'b0);
		send(CMD_PROB, 10'd0, '0, '0, 4'd1, BASIS_X, 1'b0);
		send(CMD_EXPT, 10'd0, '0, '0, 4'd0, BASIS_X, 1'b0);
		send(CMD_EXPT, 10'd0, '0, '0, 4'd0, BASIS_Y, 1'b0);
		send(CMD_EXPT, 10'd0, '0, '0, 4'd0, BASIS_Z, 1'b0);
		send(CMD_EXPT, 10'd0, '0, '0, 4'd0, BASIS_NONE, 1'b0);
		send(CMD_COLL, 10'd0, '0, '0, 4'd0, BASIS_X, 1'b1);
		send(CMD_READ, 10'd0, '0, '0, '0, BASIS_X, 1'b0);
		send(CMD_READ, 10'd1023, '0, '0, '0, BASIS_X, 1'b0);
		send(CMD_COLL, 10'd0, '0, '0, 4'd0, BASIS_X, 1'b0);
		send(CMD_LOAD, 10'd1023, 16'h1234, 16'h8000, '0, BASIS_X, 1'b0);
		send(CMD_COLL, 10'd0, '0, '0, 4'd0, BASIS_X, 1'b0);
		send(CMD_READ, 10'd1, '0, '0, '0, BASIS_X, 1'b0);
		repeat (20) random_command(1, 1'b0);

		// zero acts as one qubit
		random_phase(4'd0, 1, 20);
		random_phase(4'd2, 2, 30);

		// long sink hold-off while cheap commands keep coming
		random_phase(4'd3, 3, 20);
		hold_request = 1'b1;
		repeat (40) random_command(3, 1'b1);
		repeat (20) random_command(3, 1'b0);

		random_phase(4'd4, 4, 70);

		// above the maximum acts as the maximum size, only written entries read
		set_qubits(4'd15);
		send(CMD_LOAD, 10'd1023, 16'h4000, 16'hc000, '0, BASIS_X, 1'b0);
		send(CMD_LOAD, 10'd511, 16'h8000, 16'h0001, '0, BASIS_X, 1'b0);
		send(CMD_READ, 10'd1023, '0, '0, '0, BASIS_X, 1'b0);
		send(CMD_READ, 10'd511, '0, '0, '0, BASIS_X, 1'b0);
		send(CMD_PROB, 10'd0, '0, '0, 4'd10, BASIS_X, 1'b0);
		send(CMD_EXPT, 10'd0, '0, '0, 4'd9, BASIS_NONE, 1'b0);
		send(CMD_COLL, 10'd0, '0, '0, 4'd12, BASIS_X, 1'b1);
		send(CMD_UNDEF, 10'd0, '0, '0, '0, BASIS_X, 1'b0);

		// back to the reset size, reads only of written entries
		set_qubits(4'd10);
		send(CMD_LOAD, 10'd512, 16'h0123, 16'hfedc, '0, BASIS_X, 1'b0);
		send(CMD_READ, 10'd512, '0, '0, '0, BASIS_X, 1'b0);
		send(CMD_READ, 10'd1023, '0, '0, '0, BASIS_X, 1'b0);
		send(CMD_READ, 10'd511, '0, '0, '0, BASIS_X, 1'b0);
		send(CMD_LOAD, 10'd0, 16'h7fff, 16'h7fff, '0, BASIS_X, 1'b0);
		send(CMD_READ, 10'd0, '0, '0, '0, BASIS_X, 1'b0);

		settle();
		repeat (50) @(negedge clk);
		if (fail_count == 0)
			$display("qubit_measurement_engine_unit test passed");
		else
			$display("qubit_measurement_engine_unit test failed");
		$finish;
	end

endmodule
